// File: src/smr90_pkg.sv
// shared types and constants for the square matrix rotator
package smr90_pkg;

  localparam int DIM_W  = 7;
  localparam int ELEM_W = 32;
  localparam int OUT_W  = 32;
  localparam int STAT_W = 2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EARLY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    wr_en;
    logic    drain_en;
    logic    cap_en;
    status_t status;
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
  } dp_stat_t;

endpackage

// File: src/smr90_if.sv
// channel interfaces: item input, result output, dim configuration

interface smr90_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [smr90_pkg::ELEM_W-1:0] element;

  modport source (output valid, output kind, output element, input ready);
  modport sink (input valid, input kind, input element, output ready);
endinterface

interface smr90_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [smr90_pkg::OUT_W-1:0]  value;
  logic                                row_end;
  logic                                last;
  logic        [smr90_pkg::STAT_W-1:0] status;

  modport source (output valid, output value, output row_end, output last,
                  output status, input ready);
  modport sink (input valid, input value, input row_end, input last,
                input status, output ready);
endinterface

interface smr90_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [smr90_pkg::DIM_W-1:0]   dim;

  modport source (output valid, output dim, input ready);
  modport sink (input valid, input dim, output ready);
endinterface

// File: src/smr90_ctrl.sv
// controller state machine: decodes items and sequences result delivery
module smr90_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  smr90_pkg::dp_stat_t stat,
  output smr90_pkg::ctl_cmd_t cmd
);
  import smr90_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd.wr_en    = 1'b0;
    cmd.drain_en = 1'b0;
    cmd.cap_en   = 1'b0;
    cmd.status   = STAT_OK;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_LOAD) begin
            if (stat.full) begin
              cmd.cap_en = 1'b1;
              cmd.status = STAT_FULL;
              state_nxt  = ST_RESP;
            end else begin
              cmd.wr_en = 1'b1;
            end
          end else begin
            cmd.cap_en = 1'b1;
            state_nxt  = ST_RESP;
            if (stat.full) begin
              cmd.drain_en = 1'b1;
              cmd.status   = STAT_OK;
            end else begin
              cmd.status = STAT_EARLY;
            end
          end
        end
      end
      ST_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/smr90_dpath.sv
// datapath: dim register, matrix store, load and drain counters, result register
module smr90_dpath #(
  parameter int MAX_DIM    = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr,
  input  logic        [smr90_pkg::DIM_W-1:0]  cfg_dim,
  input  logic signed [smr90_pkg::ELEM_W-1:0] in_element,
  input  smr90_pkg::ctl_cmd_t                 cmd,
  output smr90_pkg::dp_stat_t                 stat,
  output logic signed [smr90_pkg::OUT_W-1:0]  out_value,
  output logic                                out_row_end,
  output logic                                out_last,
  output logic        [smr90_pkg::STAT_W-1:0] out_status
);
  import smr90_pkg::*;

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LCW   = $clog2(STORE_DEPTH + 1);
  localparam int CW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int IW    = (CW > DIM_W) ? CW : DIM_W;
  localparam int TOT_W = 2 * DIM_W;
  localparam int CMP_W = (LCW > TOT_W) ? LCW : TOT_W;
  localparam int SW    = AW + IW + DIM_W;

  logic [DATA_WIDTH-1:0] mem [STORE_DEPTH];

  logic [DIM_W-1:0] dim_r;
  logic [LCW-1:0]   load_cnt_r;
  logic [LCW-1:0]   load_cnt_nxt;
  logic [CW-1:0]    row_r;
  logic [CW-1:0]    row_nxt;
  logic [CW-1:0]    col_r;
  logic [CW-1:0]    col_nxt;

  logic signed [DATA_WIDTH-1:0] rd_data_r;
  status_t                      status_r;
  logic                         row_end_r;
  logic                         last_r;

  logic [DIM_W-1:0] eff_d;
  logic [DIM_W-1:0] dm1;
  logic [TOT_W-1:0] total;
  logic [IW-1:0]    r_cl;
  logic [IW-1:0]    c_cl;
  logic [SW-1:0]    rd_idx;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             row_end;
  logic             last;

  // dim register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_W'(1);
    end else if (cfg_wr) begin
      dim_r <= cfg_dim;
    end
  end

  // effective side length, clamped to 1..MAX_DIM
  always_comb begin
    if (dim_r == '0) begin
      eff_d = DIM_W'(1);
    end else if (int'(dim_r) > MAX_DIM) begin
      eff_d = DIM_W'(MAX_DIM);
    end else begin
      eff_d = dim_r;
    end
  end

  assign dm1   = eff_d - DIM_W'(1);
  assign total = TOT_W'(eff_d) * TOT_W'(eff_d);
  assign stat.full = CMP_W'(load_cnt_r) >= CMP_W'(total);

  // drain position, clamped in case dim shrank
  assign r_cl = (IW'(row_r) > IW'(dm1)) ? IW'(dm1) : IW'(row_r);
  assign c_cl = (IW'(col_r) > IW'(dm1)) ? IW'(dm1) : IW'(col_r);

  // source index: in[c][dim-1-r]
  assign rd_idx  = SW'(c_cl) * SW'(eff_d) + SW'(dm1) - SW'(r_cl);
  assign rd_addr = rd_idx[AW-1:0];
  assign wr_addr = load_cnt_r[AW-1:0];

  assign row_end = (c_cl == IW'(dm1));
  assign last    = row_end && (r_cl == IW'(dm1));

  // counter next values
  always_comb begin
    load_cnt_nxt = load_cnt_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    if (cmd.wr_en) begin
      load_cnt_nxt = load_cnt_r + LCW'(1);
    end else if (cmd.drain_en) begin
      if (last) begin
        load_cnt_nxt = '0;
        row_nxt      = '0;
        col_nxt      = '0;
      end else if (row_end) begin
        row_nxt = CW'(r_cl + IW'(1));
        col_nxt = '0;
      end else begin
        row_nxt = CW'(r_cl);
        col_nxt = CW'(c_cl + IW'(1));
      end
    end
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      row_r      <= '0;
      col_r      <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
    end
  end

  // matrix store, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= DATA_WIDTH'(in_element);
    end
    if (cmd.drain_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      status_r  <= cmd.status;
      row_end_r <= cmd.drain_en && row_end;
      last_r    <= cmd.drain_en && last;
    end
  end

  assign out_value   = (status_r == STAT_OK) ? OUT_W'(rd_data_r) : '0;
  assign out_row_end = row_end_r;
  assign out_last    = last_r;
  assign out_status  = status_r;

endmodule

// File: src/square_matrix_rotate_90.sv
// top level: 90 degree counterclockwise square matrix rotator
// loads may arrive back to back and give no result unless rejected
// a drain or rejected item shows its result in the cycle after the transfer and the next
// item is taken in the cycle after the result transfer; no new item is taken while a
// result waits, as there is a registered store read and a single result register
// reset (rst_n, synchronous) clears counters, sets dim to 1; store contents are undefined
module square_matrix_rotate_90 #(
  parameter int MAX_DIM    = 64,
  parameter int DATA_WIDTH = 32
) (
  input logic          clk,
  input logic          rst_n,
  smr90_in_if.sink     in_if,
  smr90_out_if.source  out_if,
  smr90_cfg_if.sink    cfg_if
);
  import smr90_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // dim writes are always taken
  assign cfg_if.ready = 1'b1;

  smr90_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_kind   (in_if.kind),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  smr90_dpath #(
    .MAX_DIM    (MAX_DIM),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr      (cfg_if.valid),
    .cfg_dim     (cfg_if.dim),
    .in_element  (in_if.element),
    .cmd         (cmd),
    .stat        (stat),
    .out_value   (out_if.value),
    .out_row_end (out_if.row_end),
    .out_last    (out_if.last),
    .out_status  (out_if.status)
  );

endmodule
